// ===== src/u2u8_pkg.sv =====
// shared types, constants and the per-unit utf-8 encoder function
// used by u2u8_encode, u2u8_serial and utf16le_to_utf8_transcoder
`default_nettype none

package u2u8_pkg;

  localparam int unsigned MaxBytes = 6;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;
  localparam logic [15:0] OneByteLimit = 16'h0080;
  localparam logic [15:0] TwoByteLimit = 16'h0800;

  localparam logic [7:0] LeadTwo   = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour  = 8'hF0;
  localparam logic [7:0] ContMark  = 8'h80;

  // surrogate prefix 110110 restores a held high unit from its low ten bits
  localparam logic [5:0] HighPrefix = 6'b110110;

  typedef logic [MaxBytes-1:0][7:0] byte_vec_t;

  // one item's bytes, lowest index goes out first
  typedef struct packed {
    byte_vec_t       bytes;
    logic [CntW-1:0] count;
    logic            eot;
  } run_t;

  typedef struct packed {
    logic       valid;
    logic [9:0] bits;
  } hold_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      len;
  } bmp_enc_t;

  // 1 to 3 byte encoding of a 16-bit value
  function automatic bmp_enc_t encode_bmp(input logic [15:0] cu);
    bmp_enc_t e;
    e = '0;
    if (cu < OneByteLimit) begin
      e.bytes[0] = cu[7:0];
      e.len      = 2'd1;
    end else if (cu < TwoByteLimit) begin
      e.bytes[0] = LeadTwo | {3'b000, cu[10:6]};
      e.bytes[1] = ContMark | {2'b00, cu[5:0]};
      e.len      = 2'd2;
    end else begin
      e.bytes[0] = LeadThree | {4'b0000, cu[15:12]};
      e.bytes[1] = ContMark | {2'b00, cu[11:6]};
      e.bytes[2] = ContMark | {2'b00, cu[5:0]};
      e.len      = 2'd3;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== src/u2u8_encode.sv =====
// combinational step: one code unit plus held surrogate state to a run of bytes
// depends on u2u8_pkg
`default_nettype none

module u2u8_encode (
  input  wire logic [15:0]    code_unit_i,
  input  wire logic           eot_i,
  input  wire u2u8_pkg::hold_t hold_i,
  output u2u8_pkg::run_t      run_o,
  output u2u8_pkg::hold_t     hold_o
);

  logic               is_high;
  logic               is_low;
  logic               emit_new;
  logic [4:0]         plane;
  u2u8_pkg::bmp_enc_t new_enc;
  u2u8_pkg::bmp_enc_t flush_enc;

  assign is_high = (code_unit_i >= u2u8_pkg::HighFirst) && (code_unit_i <= u2u8_pkg::HighLast);
  assign is_low  = (code_unit_i >= u2u8_pkg::LowFirst) && (code_unit_i <= u2u8_pkg::LowLast);
  assign emit_new = !(is_high && !eot_i);
  assign new_enc   = u2u8_pkg::encode_bmp(code_unit_i);
  assign flush_enc = u2u8_pkg::encode_bmp({u2u8_pkg::HighPrefix, hold_i.bits});
  // scalar bits 20:16 are the top four held bits plus one
  assign plane = {1'b0, hold_i.bits[9:6]} + 5'd1;

  always_comb begin
    run_o       = '0;
    run_o.eot   = eot_i;
    hold_o      = '0;
    if (hold_i.valid && is_low) begin
      run_o.bytes[0] = u2u8_pkg::LeadFour | {5'b00000, plane[4:2]};
      run_o.bytes[1] = u2u8_pkg::ContMark | {2'b00, plane[1:0], hold_i.bits[5:2]};
      run_o.bytes[2] = u2u8_pkg::ContMark | {2'b00, hold_i.bits[1:0], code_unit_i[9:6]};
      run_o.bytes[3] = u2u8_pkg::ContMark | {2'b00, code_unit_i[5:0]};
      run_o.count    = u2u8_pkg::CntW'(4);
    end else if (hold_i.valid) begin
      // held unit flushed as three bytes, new unit follows unless it is itself held
      run_o.bytes[2:0] = flush_enc.bytes;
      run_o.bytes[5:3] = new_enc.bytes;
      run_o.count      = u2u8_pkg::CntW'(3)
                       + (emit_new ? u2u8_pkg::CntW'(new_enc.len) : '0);
    end else begin
      run_o.bytes[2:0] = new_enc.bytes;
      run_o.count      = emit_new ? u2u8_pkg::CntW'(new_enc.len) : '0;
    end
    if (!(hold_i.valid && is_low) && is_high && !eot_i) begin
      hold_o.valid = 1'b1;
      hold_o.bits  = code_unit_i[9:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/u2u8_serial.sv =====
// result register: holds one run of up to six bytes and sends one per transaction
// depends on u2u8_pkg
`default_nettype none

module u2u8_serial (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire u2u8_pkg::run_t run_i,
  output logic                can_load_o,
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // out_byte
  output logic                m_axis_tlast,   // last_in_run
  output logic                m_axis_tuser    // text_done
);

  u2u8_pkg::byte_vec_t           buf_q;
  logic [u2u8_pkg::CntW-1:0]     cnt_q;
  logic                          eot_q;
  logic                          take;

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = buf_q[0];
  assign m_axis_tlast  = (cnt_q == u2u8_pkg::CntW'(1));
  assign m_axis_tuser  = m_axis_tlast && eot_q;
  assign take          = m_axis_tvalid && m_axis_tready;
  // a new run may follow straight on from the final byte of the current one
  assign can_load_o    = (cnt_q == '0) || (m_axis_tlast && m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      eot_q <= 1'b0;
    end else if (load_i) begin
      cnt_q <= run_i.count;
      eot_q <= run_i.eot;
    end else if (take) begin
      cnt_q <= cnt_q - u2u8_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= run_i.bytes;
    end else if (take) begin
      buf_q <= {8'h00, buf_q[u2u8_pkg::MaxBytes-1:1]};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= u2u8_pkg::CntW'(u2u8_pkg::MaxBytes))
    else $error("byte count beyond run size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("run loaded over unsent bytes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !m_axis_tlast && !load_i) |=> m_axis_tvalid)
    else $error("run ended before its last byte");

endmodule

`default_nettype wire

// ===== src/utf16le_to_utf8_transcoder.sv =====
// utf-16 code units in, utf-8 bytes out; input register, surrogate hold and result register
// depends on u2u8_pkg, u2u8_encode, u2u8_serial
// path: a unit's first byte passes the input register, then the result register, before
// it is valid; the input register stalls while the result register is busy
// throughput: one output byte per cycle while m_axis_tready is high; a run of up to six
// bytes leaves by the single byte-wide output port, the next run loading as its last is taken
// reset: asynchronous, clears the surrogate hold and both valid flags
`default_nettype none

module utf16le_to_utf8_transcoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // code_unit
  input  wire logic        s_axis_tlast,   // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_byte
  output logic             m_axis_tlast,   // last_in_run
  output logic             m_axis_tuser    // text_done
);

  logic            in_valid_q;
  logic [15:0]     in_cu_q;
  logic            in_eot_q;
  u2u8_pkg::hold_t hold_q;
  u2u8_pkg::hold_t hold_d;
  u2u8_pkg::run_t  run;
  logic            can_load;
  logic            consume;

  assign consume       = in_valid_q && can_load;
  assign s_axis_tready = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      hold_q     <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (consume) begin
        hold_q <= hold_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cu_q  <= s_axis_tdata;
      in_eot_q <= s_axis_tlast;
    end
  end

  u2u8_encode u_encode (
    .code_unit_i (in_cu_q),
    .eot_i       (in_eot_q),
    .hold_i      (hold_q),
    .run_o       (run),
    .hold_o      (hold_d)
  );

  u2u8_serial u_serial (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (consume),
    .run_i         (run),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_eot_q) |=> !hold_q.valid)
    else $error("surrogate still held after end of text");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_eot_q) |-> (run.count != '0))
    else $error("end of text produced no bytes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && (run.count == '0)) |=> hold_q.valid)
    else $error("unit dropped without being held");

endmodule

`default_nettype wire
